FILE: hdl/pgp_pkg.sv
// ----------------------------------------------------------------------------
// pgp_pkg
// shared constants and helpers for the polar gaussian pair generator
// ----------------------------------------------------------------------------
package pgp_pkg;

    localparam int unsigned UNI_W   = 31;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned CFG_W   = 21;
    localparam int unsigned LOG_BITS = 24;

    localparam logic [30:0] UNI_MAX     = 31'h7FFF_FFFF;
    localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [CFG_W-1:0] PAIR_COUNT_RST = 21'd1;

    // register indexes
    localparam logic REG_PAIR_COUNT = 1'b0;

    // rounding right shift by 43-h, then saturate to signed q4.11
    function automatic logic [OUT_W-1:0] scale_out(
        input logic [63:0] prod,
        input logic        neg,
        input logic [4:0]  h
    );
        logic [5:0]  sh;
        logic [63:0] rnd;
        logic [63:0] v;
        logic [16:0] t;
        sh  = 6'd43 - {1'b0, h};
        rnd = 64'd1 << (sh - 6'd1);
        v   = (prod + rnd) >> sh;
        t   = 17'd0;
        if (neg) begin
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            t = 17'h10000 - v[16:0];
            return t[15:0];
        end
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

endpackage

FILE: hdl/pgp_if.sv
// ----------------------------------------------------------------------------
// pgp channel interfaces
// valid/ready channels for uniform pairs in and normal pairs out
// ----------------------------------------------------------------------------
interface pgp_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] uniform_x;
    logic [30:0] uniform_y;
    modport source (output valid, output uniform_x, output uniform_y, input ready);
    modport sink   (input valid, input uniform_x, input uniform_y, output ready);
endinterface

interface pgp_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] normal_first;
    logic signed [15:0] normal_second;
    logic        last_pair;
    modport source (output valid, output normal_first, output normal_second,
                    output last_pair, input ready);
    modport sink   (input valid, input normal_first, input normal_second,
                    input last_pair, output ready);
endinterface

FILE: hdl/pgp_mul.sv
// ----------------------------------------------------------------------------
// pgp_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module pgp_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule

FILE: hdl/pgp_div.sv
// ----------------------------------------------------------------------------
// pgp_div
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module pgp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic        fit;

    assign rem_sh = {r_rem, r_q[63]};
    assign fit    = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= 32'd0;
                r_dvs  <= i_divisor;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[62:0], fit};
                r_rem <= fit ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: hdl/pgp_sqrt.sv
// ----------------------------------------------------------------------------
// pgp_sqrt
// integer square root of a 64-bit value, two radicand bits per cycle
// ----------------------------------------------------------------------------
module pgp_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_val;
                r_res  <= 64'd0;
                r_bit  <= 64'd1 << 62;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

FILE: hdl/polar_gaussian_pair_generator_unit.sv
// sequence: a pair runs through a normalize walk, 24 squaring steps of the logarithm,
//   the serial divide and the serial square root; a rejected pair frees the input
// input: no new input is taken while a pair is in work
// reset: i_rst_n synchronous active low; pair_count returns to 1, batch count to 0
// ----------------------------------------------------------------------------
// polar_gaussian_pair_generator_unit
// marsaglia polar gaussian pair generator on one shared multiplier,
// a shared serial divider and a serial square root under a sequencer
// ----------------------------------------------------------------------------
module polar_gaussian_pair_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgp_in_if.sink      i_in,
    pgp_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [4:0] {
        S_IDLE, S_MAPX, S_MAPY, S_SQX, S_SQY, S_SQSUM,
        S_CHK, S_NORM, S_LSQ, S_LACC, S_NLOG, S_GMUL, S_TDIV, S_SQRT,
        S_OX, S_OXR, S_OYR, S_DELIV
    } t_state;

    t_state r_state;

    // config and batch state
    logic [pgp_pkg::CFG_W-1:0] r_pair_count;
    logic [pgp_pkg::CFG_W-1:0] r_pairs_done;

    // per-pair working registers
    logic [30:0] r_ux, r_uy;
    logic [30:0] r_mx, r_my;
    logic        r_nx, r_ny;
    logic [60:0] r_r;
    logic [59:0] r_nr;
    logic [5:0]  r_z;
    logic [30:0] r_m;
    logic [30:0] r_mant;
    logic [23:0] r_frac;
    logic [4:0]  r_i;
    logic [31:0] r_s;
    logic [15:0] r_nf;
    logic [15:0] r_ns;

    // output register
    logic        r_ovalid;
    logic [15:0] r_of, r_os;
    logic        r_olast;

    // shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend, div_quot;
    logic [31:0] div_divisor;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;

    logic [31:0] twice;
    logic        map_neg;
    logic [30:0] map_d;
    logic [31:0] map_sum;
    logic [30:0] map_q;
    logic [6:0]  e_val;
    logic [30:0] nlog;
    logic [37:0] g_val;
    logic [38:0] g2;
    logic [4:0]  h_val;
    logic [6:0]  h_tmp;
    logic [31:0] sq_prod;
    logic [21:0] next_cnt;
    logic        is_last;
    logic        cfg_wr;
    logic        deliver;

    pgp_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    pgp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_dividend), .i_divisor(div_divisor),
        .o_busy(div_busy), .o_done(div_done), .o_quot(div_quot)
    );

    pgp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_val({8'd0, div_quot[31:0], 24'd0}), .o_done(sq_done), .o_root(sq_root)
    );

    // uniform to signed q1.30: |x| = (|2u - max| * 2^30 + 2^30-1) / max
    always_comb begin
        twice = (r_state == S_MAPX) ? {r_ux, 1'b0} : {r_uy, 1'b0};
        if (twice >= {1'b0, pgp_pkg::UNI_MAX}) begin
            map_d   = 31'(twice - {1'b0, pgp_pkg::UNI_MAX});
            map_neg = 1'b0;
        end else begin
            map_d   = 31'({1'b0, pgp_pkg::UNI_MAX} - twice);
            map_neg = 1'b1;
        end
    end

    // divide by 2^31-1: since 2^31 = 1 mod max, the quotient is the high part
    // of the dividend plus one when high part plus low part reaches max
    assign map_sum = {2'd0, map_d[30:1]} + {1'b0, map_d[0], 30'h3FFF_FFFF};
    assign map_q   = {1'b0, map_d[30:1]} +
                     {30'd0, (map_sum >= {1'b0, pgp_pkg::UNI_MAX})};

    // exponent and log terms
    assign e_val = {1'b0, r_z} + 7'd1;
    assign nlog  = {e_val, 24'd0} - {7'd0, r_frac};
    assign g_val = mul_p[61:24];
    assign g2    = r_z[0] ? {1'b0, g_val} : {g_val, 1'b0};
    assign h_tmp = e_val >> 1;
    assign h_val = h_tmp[4:0];
    assign sq_prod = mul_p[61:30];

    // multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_SQX: begin
                mul_a = {1'b0, r_mx};
                mul_b = {1'b0, r_mx};
            end
            S_SQY: begin
                mul_a = {1'b0, r_my};
                mul_b = {1'b0, r_my};
            end
            S_LSQ: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            S_NLOG: begin
                mul_a = {1'b0, nlog};
                mul_b = pgp_pkg::TWO_LN2_Q30;
            end
            S_OX: begin
                mul_a = {1'b0, r_mx};
                mul_b = r_s;
            end
            S_OXR: begin
                mul_a = {1'b0, r_my};
                mul_b = r_s;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // divider start: t = (g2 << 24) / m
    always_comb begin
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = 32'd0;
        case (r_state)
            S_GMUL: begin
                div_start    = 1'b1;
                div_dividend = {1'b0, g2, 24'd0};
                div_divisor  = {1'b0, r_mant};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sq_start = (r_state == S_TDIV) && div_done;

    // batch counter
    assign next_cnt = {1'b0, r_pairs_done} + 22'd1;
    assign is_last  = next_cnt >= {1'b0, r_pair_count};

    // result moves into the output register once it is free
    assign deliver = (r_state == S_DELIV) && (!r_ovalid || o_out.ready);

    // apb config port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pgp_pkg::REG_PAIR_COUNT) ?
                    {11'd0, r_pair_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= pgp_pkg::PAIR_COUNT_RST;
        end else if (cfg_wr && paddr[2] == pgp_pkg::REG_PAIR_COUNT) begin
            r_pair_count <= pwdata[pgp_pkg::CFG_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pairs_done <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (deliver) begin
                r_ovalid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ux    <= i_in.uniform_x;
                        r_uy    <= i_in.uniform_y;
                        r_state <= S_MAPX;
                    end
                end
                S_MAPX: begin
                    r_nx    <= map_neg;
                    r_mx    <= map_q;
                    r_state <= S_MAPY;
                end
                S_MAPY: begin
                    r_ny    <= map_neg;
                    r_my    <= map_q;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_r     <= mul_p[60:0];
                    r_state <= S_SQSUM;
                end
                S_SQSUM: begin
                    r_r     <= r_r + mul_p[60:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // zero radius, or on or outside the unit circle: reject
                    if (r_r == 61'd0 || r_r[60]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_nr    <= r_r[59:0];
                        r_z     <= 6'd0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_nr[59]) begin
                        r_m     <= r_nr[59:29];
                        r_mant  <= r_nr[59:29];
                        r_frac  <= 24'd0;
                        r_i     <= 5'd0;
                        r_state <= S_LSQ;
                    end else begin
                        r_nr <= {r_nr[58:0], 1'b0};
                        r_z  <= r_z + 6'd1;
                    end
                end
                S_LSQ: begin
                    r_state <= S_LACC;
                end
                S_LACC: begin
                    // one log2 fraction bit per squaring
                    r_frac <= {r_frac[22:0], sq_prod[31]};
                    r_m    <= sq_prod[31] ? sq_prod[31:1] : sq_prod[30:0];
                    r_i    <= r_i + 5'd1;
                    r_state <= (r_i == 5'(pgp_pkg::LOG_BITS - 1)) ? S_NLOG : S_LSQ;
                end
                S_NLOG: begin
                    r_state <= S_GMUL;
                end
                S_GMUL: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (div_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_s     <= sq_root;
                        r_state <= S_OX;
                    end
                end
                S_OX: begin
                    r_state <= S_OXR;
                end
                S_OXR: begin
                    r_nf    <= pgp_pkg::scale_out(mul_p, r_nx, h_val);
                    r_state <= S_OYR;
                end
                S_OYR: begin
                    r_ns    <= pgp_pkg::scale_out(mul_p, r_ny, h_val);
                    r_state <= S_DELIV;
                end
                S_DELIV: begin
                    // hand over once the output register is free
                    if (deliver) begin
                        r_of     <= r_nf;
                        r_os     <= r_ns;
                        r_olast  <= is_last;
                        r_pairs_done <= is_last ? '0 : next_cnt[pgp_pkg::CFG_W-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.normal_first  = r_of;
    assign o_out.normal_second = r_os;
    assign o_out.last_pair     = r_olast;

`ifndef SYNTH
    // divider is never restarted while it is still iterating
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // an accepted pair blocks further input on the next cycle
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while pair in work");

    // normalize walk never runs past the top of the square sum
    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_z <= 6'd59))
        else $error("normalize shift out of range");

    // a flagged last pair restarts the batch count
    a_batch_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deliver && is_last) |=> (r_pairs_done == '0))
        else $error("batch count did not wrap");
`endif

endmodule
